/* hdl/i2cmrt_pkg.sv */
`timescale 1ns / 1ps

package i2cmrt_pkg;

    // Write buffer geometry
    localparam int BUFFER_DEPTH = 256;
    localparam int PTR_W        = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam logic       RW_READ_BIT   = 1'b1;

    typedef enum logic [1:0] {
        CMD_TICK        = 2'd0,
        CMD_LOAD        = 2'd1,
        CMD_BEGIN_WRITE = 2'd2,
        CMD_BEGIN_READ  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_START_FAIL  = 3'd1,
        ST_ADDR_NACK   = 3'd2,
        ST_REG_NACK    = 3'd3,
        ST_DATA_NACK   = 3'd4
    } status_t;

    // Which byte of the transfer is on the bus
    typedef enum logic [1:0] {
        STG_ADDR_W = 2'd0,
        STG_REG    = 2'd1,
        STG_DATA   = 2'd2,
        STG_ADDR_R = 2'd3
    } stage_t;

    typedef enum logic [22:0] {
        PH_IDLE          = 23'h000001,
        PH_ST_HIGH       = 23'h000002,
        PH_ST_CHK1       = 23'h000004,
        PH_ST_CHK2       = 23'h000008,
        PH_TX_LOW        = 23'h000010,
        PH_TX_DATA       = 23'h000020,
        PH_TX_HIGH       = 23'h000040,
        PH_ACK_LOW       = 23'h000080,
        PH_ACK_REL       = 23'h000100,
        PH_ACK_HIGH      = 23'h000200,
        PH_ACK_SAMPLE    = 23'h000400,
        PH_RS_HIGH       = 23'h000800,
        PH_RS_LOW        = 23'h001000,
        PH_RX_HIGH       = 23'h002000,
        PH_RX_SAMPLE     = 23'h004000,
        PH_M_SDA         = 23'h008000,
        PH_M_HIGH        = 23'h010000,
        PH_M_LOW         = 23'h020000,
        PH_RX_PREP       = 23'h040000,
        PH_STOP_LOW      = 23'h080000,
        PH_STOP_SDA_LOW  = 23'h100000,
        PH_STOP_SCL_HIGH = 23'h200000,
        PH_STOP_SDA_HIGH = 23'h400000
    } phase_t;

endpackage

/* hdl/i2c_master_register_transfer.sv */
`timescale 1ns / 1ps

// I2C master for register reads and writes, stepped one bus phase per tick word.
// Load write bytes first (cmd 1), then issue a begin word (cmd 2 write, cmd 3 read)
// carrying the device address, register and length; each following tick word
// (cmd 0) samples s_sda_in and moves the bus on by one phase, the open-drain
// levels appearing on m_scl_out / m_sda_out. Every accepted word yields exactly
// one result word: line levels, any received byte, completion and status, busy.
// Rate: one word per clock cycle, the result coming in the cycle after acceptance.
// The figure is set by the single result register: s_ready drops only while that
// register holds a word the consumer has not yet taken. The write buffer is a
// 256-entry memory with a registered read port that is prefetched at the read
// pointer, so a data byte is always ready when an acknowledge hands over to it.
// Load and begin words are ignored while a transfer is in progress, and ticks
// while idle leave the bus alone. A NACK sends STOP and reports its cause.
module i2c_master_register_transfer
    import i2cmrt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_cmd,
    input  logic       s_sda_in,
    input  logic [6:0] s_dev_addr,
    input  logic [7:0] s_reg_addr,
    input  logic [7:0] s_length,
    input  logic [7:0] s_data_byte,

    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_scl_out,
    output logic       m_sda_out,
    output logic       m_rx_valid,
    output logic [7:0] m_rx_byte,
    output logic       m_rx_last,
    output logic       m_done_res,
    output logic [2:0] m_status,
    output logic       m_busy_res
);

    // Bus sequencer state
    phase_t           phase_reg,       phase_next;
    stage_t           stage_reg,       stage_next;
    logic [3:0]       bit_count_reg,   bit_count_next;
    logic [7:0]       bytes_left_reg,  bytes_left_next;
    logic [7:0]       shift_reg,       shift_next;
    logic [PTR_W-1:0] load_ptr_reg,    load_ptr_next;
    logic [PTR_W-1:0] read_ptr_reg,    read_ptr_next;
    logic             is_read_reg,     is_read_next;
    logic [6:0]       target_addr_reg, target_addr_next;
    logic [7:0]       target_reg_reg,  target_reg_next;
    status_t          fail_code_reg,   fail_code_next;
    logic             scl_reg,         scl_next;
    logic             sda_reg,         sda_next;

    // Write buffer and its prefetched read word
    logic [7:0]       wbuf_mem [BUFFER_DEPTH];
    logic [7:0]       rd_data_reg;
    logic             buf_we;

    // Result register
    logic             m_valid_reg;
    logic             m_scl_reg, m_sda_reg, m_rx_valid_reg, m_rx_last_reg;
    logic             m_done_reg, m_busy_reg;
    logic [7:0]       m_rx_byte_reg;
    status_t          m_status_reg;

    logic             accept;
    logic             finish;
    logic             rx_valid_c, rx_last_c, done_c;
    logic [7:0]       rx_byte_c;
    status_t          status_c;
    cmd_t             cmd;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(BUFFER_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    // Take a new word whenever the result register is free or being emptied
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign cmd     = cmd_t'(s_cmd);

    always_comb begin
        phase_next       = phase_reg;
        stage_next       = stage_reg;
        bit_count_next   = bit_count_reg;
        bytes_left_next  = bytes_left_reg;
        shift_next       = shift_reg;
        load_ptr_next    = load_ptr_reg;
        read_ptr_next    = read_ptr_reg;
        is_read_next     = is_read_reg;
        target_addr_next = target_addr_reg;
        target_reg_next  = target_reg_reg;
        fail_code_next   = fail_code_reg;
        scl_next         = scl_reg;
        sda_next         = sda_reg;
        buf_we           = 1'b0;
        finish           = 1'b0;
        rx_valid_c       = 1'b0;
        rx_byte_c        = '0;
        rx_last_c        = 1'b0;
        done_c           = 1'b0;
        status_c         = ST_OK;

        if (accept) begin
            if (phase_reg == PH_IDLE) begin
                // Idle: buffer a write byte or arm a transfer; ticks do nothing
                if (cmd == CMD_LOAD) begin
                    buf_we        = 1'b1;
                    load_ptr_next = ptr_inc(load_ptr_reg);
                end else if (cmd == CMD_BEGIN_WRITE || cmd == CMD_BEGIN_READ) begin
                    target_addr_next = s_dev_addr;
                    target_reg_next  = s_reg_addr;
                    bytes_left_next  = s_length;
                    is_read_next     = (cmd == CMD_BEGIN_READ);
                    read_ptr_next    = '0;
                    fail_code_next   = ST_OK;
                    phase_next       = PH_ST_HIGH;
                end
            end else if (cmd == CMD_TICK) begin
                unique case (phase_reg)
                    PH_ST_HIGH: begin
                        sda_next   = 1'b1;
                        scl_next   = 1'b1;
                        phase_next = PH_ST_CHK1;
                    end
                    PH_ST_CHK1: begin
                        // SDA must be free before we pull it low
                        if (!s_sda_in) begin
                            fail_code_next = ST_START_FAIL;
                            finish         = 1'b1;
                        end else begin
                            sda_next   = 1'b0;
                            phase_next = PH_ST_CHK2;
                        end
                    end
                    PH_ST_CHK2: begin
                        // ...and must follow us low
                        if (s_sda_in) begin
                            fail_code_next = ST_START_FAIL;
                            finish         = 1'b1;
                        end else begin
                            scl_next       = 1'b0;
                            shift_next     = {target_addr_reg, 1'b0};
                            bit_count_next = '0;
                            stage_next     = STG_ADDR_W;
                            phase_next     = PH_TX_DATA;
                        end
                    end
                    PH_TX_LOW: begin
                        scl_next   = 1'b0;
                        phase_next = PH_TX_DATA;
                    end
                    PH_TX_DATA: begin
                        sda_next   = shift_reg[7];
                        shift_next = {shift_reg[6:0], 1'b0};
                        phase_next = PH_TX_HIGH;
                    end
                    PH_TX_HIGH: begin
                        scl_next       = 1'b1;
                        bit_count_next = bit_count_reg + 1'b1;
                        phase_next     = (bit_count_next < BITS_PER_BYTE) ? PH_TX_LOW
                                                                          : PH_ACK_LOW;
                    end
                    PH_ACK_LOW: begin
                        scl_next   = 1'b0;
                        phase_next = PH_ACK_REL;
                    end
                    PH_ACK_REL: begin
                        sda_next   = 1'b1;
                        phase_next = PH_ACK_HIGH;
                    end
                    PH_ACK_HIGH: begin
                        scl_next   = 1'b1;
                        phase_next = PH_ACK_SAMPLE;
                    end
                    PH_ACK_SAMPLE: begin
                        scl_next = 1'b0;
                        if (s_sda_in) begin
                            unique case (stage_reg)
                                STG_REG:  fail_code_next = ST_REG_NACK;
                                STG_DATA: fail_code_next = ST_DATA_NACK;
                                default:  fail_code_next = ST_ADDR_NACK;
                            endcase
                            phase_next = PH_STOP_SDA_LOW;
                        end else begin
                            unique case (stage_reg)
                                STG_ADDR_W: begin
                                    shift_next     = target_reg_reg;
                                    bit_count_next = '0;
                                    stage_next     = STG_REG;
                                    phase_next     = PH_TX_DATA;
                                end
                                STG_REG: begin
                                    if (is_read_reg) begin
                                        phase_next = PH_RS_HIGH;
                                    end else if (bytes_left_reg != '0) begin
                                        shift_next     = rd_data_reg;
                                        read_ptr_next  = ptr_inc(read_ptr_reg);
                                        bit_count_next = '0;
                                        stage_next     = STG_DATA;
                                        phase_next     = PH_TX_DATA;
                                    end else begin
                                        phase_next = PH_STOP_SDA_LOW;
                                    end
                                end
                                STG_DATA: begin
                                    if (bytes_left_reg != '0) begin
                                        bytes_left_next = bytes_left_reg - 1'b1;
                                    end
                                    if (bytes_left_next != '0) begin
                                        shift_next     = rd_data_reg;
                                        read_ptr_next  = ptr_inc(read_ptr_reg);
                                        bit_count_next = '0;
                                        stage_next     = STG_DATA;
                                        phase_next     = PH_TX_DATA;
                                    end else begin
                                        phase_next = PH_STOP_SDA_LOW;
                                    end
                                end
                                STG_ADDR_R: begin
                                    if (bytes_left_reg != '0) begin
                                        sda_next       = 1'b1;
                                        bit_count_next = '0;
                                        shift_next     = '0;
                                        phase_next     = PH_RX_HIGH;
                                    end else begin
                                        phase_next = PH_STOP_SDA_LOW;
                                    end
                                end
                            endcase
                        end
                    end
                    PH_RS_HIGH: begin
                        sda_next   = 1'b1;
                        scl_next   = 1'b1;
                        phase_next = PH_RS_LOW;
                    end
                    PH_RS_LOW: begin
                        sda_next       = 1'b0;
                        shift_next     = {target_addr_reg, RW_READ_BIT};
                        bit_count_next = '0;
                        stage_next     = STG_ADDR_R;
                        phase_next     = PH_TX_LOW;
                    end
                    PH_RX_HIGH: begin
                        scl_next       = 1'b1;
                        bit_count_next = bit_count_reg + 1'b1;
                        phase_next     = PH_RX_SAMPLE;
                    end
                    PH_RX_SAMPLE: begin
                        shift_next = {shift_reg[6:0], s_sda_in};
                        scl_next   = 1'b0;
                        if (bit_count_reg < BITS_PER_BYTE) begin
                            phase_next = PH_RX_HIGH;
                        end else begin
                            rx_valid_c = 1'b1;
                            rx_byte_c  = shift_next;
                            rx_last_c  = (bytes_left_reg == 8'd1);
                            phase_next = PH_M_SDA;
                        end
                    end
                    PH_M_SDA: begin
                        // NACK the final byte, ACK the rest
                        sda_next   = (bytes_left_reg <= 8'd1);
                        phase_next = PH_M_HIGH;
                    end
                    PH_M_HIGH: begin
                        scl_next   = 1'b1;
                        phase_next = PH_M_LOW;
                    end
                    PH_M_LOW: begin
                        scl_next = 1'b0;
                        if (bytes_left_reg != '0) begin
                            bytes_left_next = bytes_left_reg - 1'b1;
                        end
                        phase_next = (bytes_left_next != '0) ? PH_RX_PREP : PH_STOP_LOW;
                    end
                    PH_RX_PREP: begin
                        sda_next       = 1'b1;
                        scl_next       = 1'b0;
                        bit_count_next = '0;
                        shift_next     = '0;
                        phase_next     = PH_RX_HIGH;
                    end
                    PH_STOP_LOW: begin
                        scl_next   = 1'b0;
                        phase_next = PH_STOP_SDA_LOW;
                    end
                    PH_STOP_SDA_LOW: begin
                        sda_next   = 1'b0;
                        phase_next = PH_STOP_SCL_HIGH;
                    end
                    PH_STOP_SCL_HIGH: begin
                        scl_next   = 1'b1;
                        phase_next = PH_STOP_SDA_HIGH;
                    end
                    PH_STOP_SDA_HIGH: begin
                        sda_next = 1'b1;
                        finish   = 1'b1;
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase

                // Close the transfer: report, and drop the loaded bytes after a write
                if (finish) begin
                    done_c     = 1'b1;
                    status_c   = fail_code_next;
                    phase_next = PH_IDLE;
                    if (!is_read_reg) begin
                        load_ptr_next = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            stage_reg       <= STG_ADDR_W;
            bit_count_reg   <= '0;
            bytes_left_reg  <= '0;
            shift_reg       <= '0;
            load_ptr_reg    <= '0;
            read_ptr_reg    <= '0;
            is_read_reg     <= 1'b0;
            target_addr_reg <= '0;
            target_reg_reg  <= '0;
            fail_code_reg   <= ST_OK;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
        end else begin
            phase_reg       <= phase_next;
            stage_reg       <= stage_next;
            bit_count_reg   <= bit_count_next;
            bytes_left_reg  <= bytes_left_next;
            shift_reg       <= shift_next;
            load_ptr_reg    <= load_ptr_next;
            read_ptr_reg    <= read_ptr_next;
            is_read_reg     <= is_read_next;
            target_addr_reg <= target_addr_next;
            target_reg_reg  <= target_reg_next;
            fail_code_reg   <= fail_code_next;
            scl_reg         <= scl_next;
            sda_reg         <= sda_next;
        end
    end

    // Write buffer: write on load, keep the word at the read pointer prefetched.
    // A pointer move is followed by many ticks before the byte is needed.
    always_ff @(posedge aclk) begin
        if (buf_we) begin
            wbuf_mem[load_ptr_reg] <= s_data_byte;
        end
        rd_data_reg <= wbuf_mem[read_ptr_reg];
    end

    // Result register: hold the word until the consumer takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_scl_reg      <= scl_next;
            m_sda_reg      <= sda_next;
            m_rx_valid_reg <= rx_valid_c;
            m_rx_byte_reg  <= rx_byte_c;
            m_rx_last_reg  <= rx_last_c;
            m_done_reg     <= done_c;
            m_status_reg   <= status_c;
            m_busy_reg     <= (phase_next != PH_IDLE);
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_scl_out  = m_scl_reg;
    assign m_sda_out  = m_sda_reg;
    assign m_rx_valid = m_rx_valid_reg;
    assign m_rx_byte  = m_rx_byte_reg;
    assign m_rx_last  = m_rx_last_reg;
    assign m_done_res = m_done_reg;
    assign m_status   = m_status_reg;
    assign m_busy_res = m_busy_reg;

    // A finished transfer never reports busy
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_done_reg) |-> !m_busy_reg)
        else $error("done reported while still busy");

    // A failure code only accompanies completion
    a_status_with_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg != ST_OK)) |-> m_done_reg)
        else $error("status set without done");

    // A received byte is always followed by its acknowledge phases
    a_rx_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_rx_valid_reg) |-> (m_busy_reg && !m_done_reg))
        else $error("received byte outside a transfer");

    // SDA only changes for a data bit while SCL is held low
    a_scl_low_for_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_TX_DATA) |-> !scl_reg)
        else $error("data bit placed while SCL high");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

// Register-transfer I2C master: self-checking bench.
// A bus model inside the bench tracks the phase sequencer, the write buffer and
// the line levels, and predicts the one result word that every accepted input
// word produces. The stimulus side plays the attached device: it answers the
// start checks, acknowledges bytes and supplies read data, with faults injected
// on purpose (line held low, line stuck high, NACK on each byte kind). A checker
// compares every result word, field by field, with the oldest prediction.
module tb;
    import i2cmrt_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int TOTAL_WORDS = 1450;
    localparam int IDLE_PCT    = 21;
    localparam int SETTLE      = 10;

    // How the attached device misbehaves during one transfer
    typedef enum int {
        FLT_NONE,
        FLT_LINE_LOW,      // SDA already low before START
        FLT_LINE_STUCK,    // SDA still high after START pulls it low
        FLT_NACK_ADDR,
        FLT_NACK_REG,
        FLT_NACK_DATA,
        FLT_NACK_RADDR,
        FLT_RANDOM
    } fault_t;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       rx_last;
        logic       done;
        status_t    status;
        logic       busy;
    } bus_word_t;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic [1:0] s_cmd       = CMD_TICK;
    logic       s_sda_in    = 1'b1;
    logic [6:0] s_dev_addr  = '0;
    logic [7:0] s_reg_addr  = '0;
    logic [7:0] s_length    = '0;
    logic [7:0] s_data_byte = '0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic       m_scl_out;
    logic       m_sda_out;
    logic       m_rx_valid;
    logic [7:0] m_rx_byte;
    logic       m_rx_last;
    logic       m_done_res;
    logic [2:0] m_status;
    logic       m_busy_res;

    // Bus model state
    phase_t           ph_q   = PH_IDLE;
    stage_t           stg_q  = STG_ADDR_W;
    logic [3:0]       bitn_q = '0;
    logic [7:0]       left_q = '0;
    logic [7:0]       shf_q  = '0;
    logic [PTR_W-1:0] ldp_q  = '0;
    logic [PTR_W-1:0] rdp_q  = '0;
    logic             rd_q   = 1'b0;
    logic [6:0]       tadr_q = '0;
    logic [7:0]       treg_q = '0;
    status_t          fail_q = ST_OK;
    logic             scl_q  = 1'b1;
    logic             sda_q  = 1'b1;
    logic [7:0]       wr_mem [BUFFER_DEPTH];
    bit               wr_seen [BUFFER_DEPTH] = '{default: 1'b0};

    bus_word_t bus_words_due [$];
    bus_word_t head_w;
    int        errors     = 0;
    int        sent_words = 0;
    int        cycles     = 0;
    bit        calm       = 1'b0;   // suppress idling on both sides

    i2c_master_register_transfer DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_sda_in    (s_sda_in),
        .s_dev_addr  (s_dev_addr),
        .s_reg_addr  (s_reg_addr),
        .s_length    (s_length),
        .s_data_byte (s_data_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_scl_out   (m_scl_out),
        .m_sda_out   (m_sda_out),
        .m_rx_valid  (m_rx_valid),
        .m_rx_byte   (m_rx_byte),
        .m_rx_last   (m_rx_last),
        .m_done_res  (m_done_res),
        .m_status    (m_status),
        .m_busy_res  (m_busy_res)
    );

    always #5 aclk = ~aclk;

    function automatic bit chance(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // Take the next buffered byte for transmission
    function automatic void pull_tx_byte();
        shf_q  = wr_mem[rdp_q];
        rdp_q  = rdp_q + 1'b1;
        bitn_q = '0;
        stg_q  = STG_DATA;
        ph_q   = PH_TX_DATA;
    endfunction

    // Advance the bus model by one accepted word and return the result word it gives
    function automatic bus_word_t advance_bus_model(input cmd_t c, input logic sda,
            input logic [6:0] dev, input logic [7:0] rga, input logic [7:0] len,
            input logic [7:0] db);
        bus_word_t w;
        logic      fin;
        w   = '0;
        fin = 1'b0;
        if (ph_q == PH_IDLE) begin
            if (c == CMD_LOAD) begin
                wr_mem[ldp_q]  = db;
                wr_seen[ldp_q] = 1'b1;
                ldp_q          = ldp_q + 1'b1;
            end else if (c != CMD_TICK) begin
                tadr_q = dev;
                treg_q = rga;
                left_q = len;
                rd_q   = (c == CMD_BEGIN_READ);
                rdp_q  = '0;
                fail_q = ST_OK;
                ph_q   = PH_ST_HIGH;
            end
        end else if (c == CMD_TICK) begin
            case (ph_q)
                PH_ST_HIGH: begin
                    sda_q = 1'b1;
                    scl_q = 1'b1;
                    ph_q  = PH_ST_CHK1;
                end
                PH_ST_CHK1: begin
                    if (!sda) begin
                        fail_q = ST_START_FAIL;
                        fin    = 1'b1;
                    end else begin
                        sda_q = 1'b0;
                        ph_q  = PH_ST_CHK2;
                    end
                end
                PH_ST_CHK2: begin
                    if (sda) begin
                        fail_q = ST_START_FAIL;
                        fin    = 1'b1;
                    end else begin
                        scl_q  = 1'b0;
                        shf_q  = {tadr_q, 1'b0};
                        bitn_q = '0;
                        stg_q  = STG_ADDR_W;
                        ph_q   = PH_TX_DATA;
                    end
                end
                PH_TX_LOW: begin
                    scl_q = 1'b0;
                    ph_q  = PH_TX_DATA;
                end
                PH_TX_DATA: begin
                    sda_q = shf_q[7];
                    shf_q = shf_q << 1;
                    ph_q  = PH_TX_HIGH;
                end
                PH_TX_HIGH: begin
                    scl_q  = 1'b1;
                    bitn_q = bitn_q + 1'b1;
                    ph_q   = (bitn_q < BITS_PER_BYTE) ? PH_TX_LOW : PH_ACK_LOW;
                end
                PH_ACK_LOW: begin
                    scl_q = 1'b0;
                    ph_q  = PH_ACK_REL;
                end
                PH_ACK_REL: begin
                    sda_q = 1'b1;
                    ph_q  = PH_ACK_HIGH;
                end
                PH_ACK_HIGH: begin
                    scl_q = 1'b1;
                    ph_q  = PH_ACK_SAMPLE;
                end
                PH_ACK_SAMPLE: begin
                    scl_q = 1'b0;
                    if (sda) begin
                        fail_q = (stg_q == STG_REG)  ? ST_REG_NACK :
                                 (stg_q == STG_DATA) ? ST_DATA_NACK : ST_ADDR_NACK;
                        ph_q   = PH_STOP_SDA_LOW;
                    end else begin
                        case (stg_q)
                            STG_ADDR_W: begin
                                shf_q  = treg_q;
                                bitn_q = '0;
                                stg_q  = STG_REG;
                                ph_q   = PH_TX_DATA;
                            end
                            STG_REG: begin
                                if (rd_q)
                                    ph_q = PH_RS_HIGH;
                                else if (left_q != 0)
                                    pull_tx_byte();
                                else
                                    ph_q = PH_STOP_SDA_LOW;
                            end
                            STG_DATA: begin
                                if (left_q != 0)
                                    left_q = left_q - 1'b1;
                                if (left_q != 0)
                                    pull_tx_byte();
                                else
                                    ph_q = PH_STOP_SDA_LOW;
                            end
                            default: begin
                                if (left_q != 0) begin
                                    sda_q  = 1'b1;
                                    bitn_q = '0;
                                    shf_q  = '0;
                                    ph_q   = PH_RX_HIGH;
                                end else begin
                                    ph_q = PH_STOP_SDA_LOW;
                                end
                            end
                        endcase
                    end
                end
                PH_RS_HIGH: begin
                    sda_q = 1'b1;
                    scl_q = 1'b1;
                    ph_q  = PH_RS_LOW;
                end
                PH_RS_LOW: begin
                    sda_q  = 1'b0;
                    shf_q  = {tadr_q, RW_READ_BIT};
                    bitn_q = '0;
                    stg_q  = STG_ADDR_R;
                    ph_q   = PH_TX_LOW;
                end
                PH_RX_HIGH: begin
                    scl_q  = 1'b1;
                    bitn_q = bitn_q + 1'b1;
                    ph_q   = PH_RX_SAMPLE;
                end
                PH_RX_SAMPLE: begin
                    shf_q = {shf_q[6:0], sda};
                    scl_q = 1'b0;
                    if (bitn_q < BITS_PER_BYTE) begin
                        ph_q = PH_RX_HIGH;
                    end else begin
                        w.rx_valid = 1'b1;
                        w.rx_byte  = shf_q;
                        w.rx_last  = (left_q == 8'd1);
                        ph_q       = PH_M_SDA;
                    end
                end
                PH_M_SDA: begin
                    sda_q = (left_q <= 8'd1);
                    ph_q  = PH_M_HIGH;
                end
                PH_M_HIGH: begin
                    scl_q = 1'b1;
                    ph_q  = PH_M_LOW;
                end
                PH_M_LOW: begin
                    scl_q = 1'b0;
                    if (left_q != 0)
                        left_q = left_q - 1'b1;
                    ph_q = (left_q != 0) ? PH_RX_PREP : PH_STOP_LOW;
                end
                PH_RX_PREP: begin
                    sda_q  = 1'b1;
                    scl_q  = 1'b0;
                    bitn_q = '0;
                    shf_q  = '0;
                    ph_q   = PH_RX_HIGH;
                end
                PH_STOP_LOW: begin
                    scl_q = 1'b0;
                    ph_q  = PH_STOP_SDA_LOW;
                end
                PH_STOP_SDA_LOW: begin
                    sda_q = 1'b0;
                    ph_q  = PH_STOP_SCL_HIGH;
                end
                PH_STOP_SCL_HIGH: begin
                    scl_q = 1'b1;
                    ph_q  = PH_STOP_SDA_HIGH;
                end
                default: begin
                    sda_q = 1'b1;
                    fin   = 1'b1;
                end
            endcase
            if (fin) begin
                w.done   = 1'b1;
                w.status = fail_q;
                if (!rd_q)
                    ldp_q = '0;
                ph_q = PH_IDLE;
            end
        end
        w.scl  = scl_q;
        w.sda  = sda_q;
        w.busy = (ph_q != PH_IDLE);
        return w;
    endfunction

    // Number of buffer entries written in an unbroken run from entry 0; a write
    // transfer never sends more, so no unwritten entry is ever put on the bus
    function automatic int written_run();
        int n;
        n = 0;
        while (n < BUFFER_DEPTH && wr_seen[n])
            n++;
        return n;
    endfunction

    // SDA level the attached device shows on the next tick, given the phase ahead
    function automatic logic device_sda(input fault_t f);
        case (ph_q)
            PH_ST_CHK1:
                return !(f == FLT_LINE_LOW || (f == FLT_RANDOM && chance(4)));
            PH_ST_CHK2:
                return f == FLT_LINE_STUCK || (f == FLT_RANDOM && chance(4));
            PH_ACK_SAMPLE: begin
                case (f)
                    FLT_NACK_ADDR:  return stg_q == STG_ADDR_W;
                    FLT_NACK_REG:   return stg_q == STG_REG;
                    FLT_NACK_DATA:  return stg_q == STG_DATA;
                    FLT_NACK_RADDR: return stg_q == STG_ADDR_R;
                    FLT_RANDOM:     return chance(4);
                    default:        return 1'b0;
                endcase
            end
            default:
                return 1'($urandom_range(0, 1));
        endcase
    endfunction

    // Present one word, hold it until accepted, then predict its result
    task automatic send_word(input cmd_t c, input logic sda, input logic [6:0] dev,
            input logic [7:0] rga, input logic [7:0] len, input logic [7:0] db);
        while (!calm && chance(IDLE_PCT)) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_cmd       <= c;
        s_sda_in    <= sda;
        s_dev_addr  <= dev;
        s_reg_addr  <= rga;
        s_length    <= len;
        s_data_byte <= db;
        do
            @(posedge aclk);
        while (!s_ready);
        sent_words++;
        bus_words_due.push_back(advance_bus_model(c, sda, dev, rga, len, db));
    endtask

    // Word with random content; a begin word only while a transfer runs
    task automatic send_noise(input cmd_t c);
        send_word(c, 1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
    endtask

    task automatic load_word(input logic [7:0] db);
        send_word(CMD_LOAD, 1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), db);
    endtask

    task automatic start_transfer(input cmd_t c, input logic [6:0] dev,
            input logic [7:0] rga, input int len);
        if (c == CMD_BEGIN_WRITE && len > written_run())
            len = written_run();
        send_word(c, 1'($urandom_range(0, 1)), dev, rga, len[7:0],
                  8'($urandom_range(0, 255)));
    endtask

    // Tick until the transfer ends, playing the device; some words are busy noise
    task automatic finish_transfer(input fault_t f, input int noise_pct);
        while (ph_q != PH_IDLE) begin
            if (chance(noise_pct))
                send_noise(cmd_t'($urandom_range(CMD_LOAD, CMD_BEGIN_READ)));
            else
                send_word(CMD_TICK, device_sda(f), 7'($urandom_range(0, 127)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_transfer(input cmd_t c, input logic [6:0] dev,
            input logic [7:0] rga, input int len, input fault_t f, input int noise_pct);
        start_transfer(c, dev, rga, len);
        finish_transfer(f, noise_pct);
    endtask

    // Drop valid and hold off until every predicted word has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (bus_words_due.size() != 0)
            @(posedge aclk);
    endtask

    task automatic test_idle_words();
        send_word(CMD_TICK, 1'b0, 7'h00, 8'h00, 8'h00, 8'h00);
        send_word(CMD_TICK, 1'b1, 7'h7F, 8'hFF, 8'hFF, 8'hFF);
        drain_results();
    endtask

    task automatic test_write_basic();
        load_word(8'h00);
        load_word(8'hFF);
        load_word(8'hA5);
        run_transfer(CMD_BEGIN_WRITE, 7'h7F, 8'h00, 3, FLT_NONE, 0);
        drain_results();
    endtask

    task automatic test_read_basic();
        run_transfer(CMD_BEGIN_READ, 7'h00, 8'hFF, 2, FLT_NONE, 0);
        drain_results();
    endtask

    task automatic test_zero_length();
        run_transfer(CMD_BEGIN_WRITE, 7'h2A, 8'h81, 0, FLT_NONE, 0);
        run_transfer(CMD_BEGIN_READ, 7'h55, 8'h7E, 0, FLT_NONE, 0);
        drain_results();
    endtask

    // Load and begin words arriving mid-transfer must leave it untouched
    task automatic test_busy_words();
        start_transfer(CMD_BEGIN_READ, 7'h19, 8'h42, 1);
        send_word(CMD_LOAD, 1'b0, 7'h11, 8'h22, 8'h33, 8'h5A);
        send_word(CMD_BEGIN_WRITE, 1'b1, 7'h66, 8'h77, 8'h88, 8'h99);
        send_word(CMD_BEGIN_READ, 1'b0, 7'h01, 8'h02, 8'h80, 8'h04);
        finish_transfer(FLT_NONE, 0);
        drain_results();
    endtask

    task automatic test_start_fail();
        run_transfer(CMD_BEGIN_WRITE, 7'h33, 8'h10, 1, FLT_LINE_LOW, 0);
        run_transfer(CMD_BEGIN_READ, 7'h44, 8'h20, 1, FLT_LINE_STUCK, 0);
        drain_results();
    endtask

    task automatic test_nacks();
        load_word(8'h3C);
        load_word(8'hC3);
        run_transfer(CMD_BEGIN_WRITE, 7'h50, 8'h01, 2, FLT_NACK_ADDR, 0);
        load_word(8'h81);
        load_word(8'h7E);
        run_transfer(CMD_BEGIN_WRITE, 7'h51, 8'h02, 2, FLT_NACK_REG, 0);
        load_word(8'h18);
        load_word(8'hE7);
        run_transfer(CMD_BEGIN_WRITE, 7'h52, 8'h03, 2, FLT_NACK_DATA, 0);
        run_transfer(CMD_BEGIN_READ, 7'h55, 8'h06, 2, FLT_NACK_RADDR, 0);
        drain_results();
    endtask

    // Loads back to back with no idling on either side; the load count passes
    // the buffer depth, so the pointer wraps and the first entries are overwritten
    task automatic test_long_transfers();
        calm = 1'b1;
        repeat (BUFFER_DEPTH + 2)
            load_word(8'($urandom_range(0, 255)));
        run_transfer(CMD_BEGIN_WRITE, 7'h2D, 8'hD2, 3, FLT_NONE, 0);
        calm = 1'b0;
        drain_results();
    endtask

    task automatic test_random();
        int     r;
        int     n;
        fault_t f;
        while (sent_words < TOTAL_WORDS) begin
            r = $urandom_range(0, 99);
            n = chance(5) ? $urandom_range(4, 8) : $urandom_range(0, 3);
            if (chance(70))
                f = FLT_NONE;
            else if (chance(50))
                f = FLT_RANDOM;
            else
                f = fault_t'($urandom_range(FLT_LINE_LOW, FLT_NACK_RADDR));
            if (r < 6) begin
                send_noise(CMD_TICK);
            end else if (r < 18) begin
                repeat ($urandom_range(1, 6))
                    load_word(8'($urandom_range(0, 255)));
            end else if (r < 58) begin
                repeat (n)
                    load_word(8'($urandom_range(0, 255)));
                run_transfer(CMD_BEGIN_WRITE, 7'($urandom_range(0, 127)),
                             8'($urandom_range(0, 255)), n, f, 4);
            end else begin
                run_transfer(CMD_BEGIN_READ, 7'($urandom_range(0, 127)),
                             8'($urandom_range(0, 255)), n, f, 4);
            end
            if (chance(3))
                drain_results();
        end
        drain_results();
    endtask

    task automatic check_field(input string fname, input logic [7:0] want,
            input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", fname, want, got);
            errors++;
        end
    endtask

    // Consumer side: stall at random except during the calm stretch
    always @(posedge aclk)
        m_ready <= calm || !chance(IDLE_PCT);

    // Compare each result word taken with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (bus_words_due.size() == 0) begin
                $error("result word arrived with nothing predicted");
                errors++;
            end else begin
                head_w = bus_words_due.pop_front();
                check_field("scl_out", 8'(head_w.scl), 8'(m_scl_out));
                check_field("sda_out", 8'(head_w.sda), 8'(m_sda_out));
                check_field("rx_valid", 8'(head_w.rx_valid), 8'(m_rx_valid));
                check_field("rx_byte", head_w.rx_byte, m_rx_byte);
                check_field("rx_last", 8'(head_w.rx_last), 8'(m_rx_last));
                check_field("done_res", 8'(head_w.done), 8'(m_done_res));
                check_field("status", 8'(head_w.status), 8'(m_status));
                check_field("busy_res", 8'(head_w.busy), 8'(m_busy_res));
            end
        end
    end

    // Watchdog: a stuck handshake ends the run here
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_idle_words();
        test_write_basic();
        test_read_basic();
        test_zero_length();
        test_busy_words();
        test_start_fail();
        test_nacks();
        test_long_transfers();
        test_random();
        drain_results();
        // let any stray word surface before the verdict
        repeat (SETTLE) @(posedge aclk);
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
